### hw/rtl/ttb_pkg.sv
// Package for the triangle tangent basis core: widths, vertex type and result type.
// No dependencies.
package ttb_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned DeltaWidth = CoordWidth + 1;
  localparam int unsigned ProdWidth  = 2 * DeltaWidth;
  localparam int unsigned DetWidth   = ProdWidth + 1;
  localparam int unsigned FracShift  = 20;
  localparam int unsigned NumWidth   = DetWidth + FracShift;
  localparam int unsigned OutWidth   = 32;
  localparam int unsigned CntWidth   = $clog2(NumWidth + 1);

  typedef struct packed {
    logic signed [OutWidth-1:0] tangent_x;
    logic signed [OutWidth-1:0] tangent_y;
    logic signed [OutWidth-1:0] tangent_z;
    logic signed [OutWidth-1:0] bitangent_x;
    logic signed [OutWidth-1:0] bitangent_y;
    logic signed [OutWidth-1:0] bitangent_z;
    logic                       degenerate;
    logic                       clipped;
  } result_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] pos_x;
    logic signed [CoordWidth-1:0] pos_y;
    logic signed [CoordWidth-1:0] pos_z;
    logic signed [CoordWidth-1:0] tex_u;
    logic signed [CoordWidth-1:0] tex_v;
  } vertex_t;

endpackage

### hw/rtl/ttb_if.sv
// Valid/ready stream interface carrying one payload of type payload_t.
// Depends on ttb_pkg for the payload types used by the top level.
interface ttb_if #(
  parameter type payload_t = ttb_pkg::vertex_t
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/triangle_tangent_basis_core.sv
// Triangle tangent basis core: holds two vertices, computes the basis on the third.
// Depends on ttb_pkg and ttb_if.
//
// One vertex request is taken per cycle for the first two vertices of a triangle.
// The third vertex starts a sequenced computation. One shared 17x17 signed
// multiplier forms det and the six numerators. That is 14 products, one per cycle,
// and the last one is folded in from the product register in the cycle after.
// One restoring divider then produces the six quotients at one bit per cycle.
// Each quotient is formed from a load and 55 quotient bits, then saturated in StFix.
// A zero determinant skips the divider: the sequencer leaves StMul for StOut
// as soon as det is formed. The result is held in an output register until
// taken, and the input is not ready while a triangle is being computed or its
// result waits.
module triangle_tangent_basis_core (
  input logic        clk_i,
  input logic        rst_ni,
  ttb_if.sink        vtx_i,
  ttb_if.source      res_o
);

  localparam int unsigned DW = ttb_pkg::DeltaWidth;
  localparam int unsigned PW = ttb_pkg::ProdWidth;
  localparam int unsigned TW = ttb_pkg::DetWidth;
  localparam int unsigned NW = ttb_pkg::NumWidth;
  localparam int unsigned OW = ttb_pkg::OutWidth;
  localparam int unsigned CW = ttb_pkg::CntWidth;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StFix  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [1:0]  slot_q;
  logic [3:0]  step_q;
  logic [2:0]  comp_q;
  logic [CW-1:0] bit_q;

  ttb_pkg::vertex_t v0_q, v1_q;

  // deltas of the current triangle
  logic signed [DW-1:0] e1_q [3];
  logic signed [DW-1:0] e2_q [3];
  logic signed [DW-1:0] du1_q, dv1_q, du2_q, dv2_q;

  logic signed [PW-1:0] prod_q;
  logic signed [TW-1:0] det_q;
  logic signed [TW-1:0] num_q [6];
  logic signed [OW-1:0] quo_q [6];
  logic                 clip_q, degen_q;

  // divider state
  logic [NW-1:0] dvd_q;
  logic [TW:0]   rem_q;
  logic [NW-1:0] qt_q;

  logic accept;
  assign vtx_i.ready = (state_q == StIdle);
  assign accept      = vtx_i.valid & vtx_i.ready;

  // shared multiplier: steps 0 and 1 form det, then one pair per component,
  // tangent x/y/z first, bitangent x/y/z after
  logic signed [DW-1:0] ma, mb;
  logic signed [PW-1:0] prod_d;
  logic [3:0] mpair, apair;
  logic [2:0] mcomp, acc_c;
  logic [1:0] maxis;
  always_comb begin
    mpair = step_q - 4'd2;
    mcomp = mpair[3:1];
    apair = step_q - 4'd3;
    acc_c = apair[3:1];
    unique case (mcomp)
      3'd0, 3'd3: maxis = 2'd0;
      3'd1, 3'd4: maxis = 2'd1;
      default:    maxis = 2'd2;
    endcase
    if (step_q == 4'd0) begin
      ma = du1_q; mb = dv2_q;
    end else if (step_q == 4'd1) begin
      ma = du2_q; mb = dv1_q;
    end else if (mcomp < 3'd3) begin
      ma = step_q[0] ? dv1_q : dv2_q;
      mb = step_q[0] ? e2_q[maxis] : e1_q[maxis];
    end else begin
      ma = step_q[0] ? du2_q : du1_q;
      mb = step_q[0] ? e1_q[maxis] : e2_q[maxis];
    end
    prod_d = ma * mb;
  end

  // divider magnitude operands
  logic signed [TW-1:0] cur_num;
  logic                 neg;
  logic [TW-1:0]        den_mag;
  logic [NW-1:0]        num_mag;
  logic [TW:0]          rem_sh, rem_sub;
  always_comb begin
    cur_num = num_q[comp_q];
    neg     = cur_num[TW-1] ^ det_q[TW-1];
    den_mag = det_q[TW-1] ? TW'(-det_q) : TW'(det_q);
    num_mag = {(cur_num[TW-1] ? TW'(-cur_num) : TW'(cur_num)), {ttb_pkg::FracShift{1'b0}}};
    rem_sh  = {rem_q[TW-1:0], dvd_q[NW-1]};
    rem_sub = rem_sh - {1'b0, den_mag};
  end

  logic [OW:0] lim;
  logic        ovf;
  always_comb begin
    lim = neg ? {1'b0, 1'b1, {(OW-1){1'b0}}} : {2'b00, {(OW-1){1'b1}}};
    ovf = (qt_q[NW-1:OW] != '0) || ({1'b0, qt_q[OW-1:0]} > lim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      slot_q  <= 2'd0;
      step_q  <= '0;
      comp_q  <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
      unique case (state_q)
        StIdle: begin step_q <= '0; comp_q <= '0; bit_q <= '0; end
        StMul: step_q <= step_q + 4'd1;
        StDiv: bit_q <= bit_q + CW'(1);
        StFix: begin
          bit_q  <= '0;
          comp_q <= (comp_q == 3'd5) ? 3'd0 : comp_q + 3'd1;
        end
        default: ;
      endcase
    end
  end

  // sequencer next state
  logic mul_last;
  assign mul_last = (step_q == 4'd14);
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept && slot_q == 2'd2) state_d = StMul;
      StMul: begin
        if (step_q == 4'd2 && det_q == TW'(prod_q)) state_d = StOut;
        else if (mul_last) state_d = StDiv;
      end
      StDiv: if (bit_q == CW'(NW)) state_d = StFix;
      StFix: state_d = (comp_q == 3'd5) ? StOut : StDiv;
      StOut: if (res_o.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (slot_q == 2'd0) v0_q <= vtx_i.data;
      if (slot_q == 2'd1) v1_q <= vtx_i.data;
      if (slot_q == 2'd2) begin
        e1_q[0] <= DW'(v1_q.pos_x) - DW'(v0_q.pos_x);
        e1_q[1] <= DW'(v1_q.pos_y) - DW'(v0_q.pos_y);
        e1_q[2] <= DW'(v1_q.pos_z) - DW'(v0_q.pos_z);
        e2_q[0] <= DW'(vtx_i.data.pos_x) - DW'(v0_q.pos_x);
        e2_q[1] <= DW'(vtx_i.data.pos_y) - DW'(v0_q.pos_y);
        e2_q[2] <= DW'(vtx_i.data.pos_z) - DW'(v0_q.pos_z);
        du1_q   <= DW'(v1_q.tex_u) - DW'(v0_q.tex_u);
        dv1_q   <= DW'(v1_q.tex_v) - DW'(v0_q.tex_v);
        du2_q   <= DW'(vtx_i.data.tex_u) - DW'(v0_q.tex_u);
        dv2_q   <= DW'(vtx_i.data.tex_v) - DW'(v0_q.tex_v);
        clip_q  <= 1'b0;
        degen_q <= 1'b0;
      end
    end
    if (state_q == StMul) begin
      prod_q <= prod_d;
      // products arrive through the prod_q register; first of a pair loads, second subtracts
      if (step_q == 4'd1) det_q <= TW'(prod_q);
      else if (step_q == 4'd2) begin
        det_q <= det_q - TW'(prod_q);
        if (det_q == TW'(prod_q)) begin
          degen_q <= 1'b1;
          for (int i = 0; i < 6; i++) quo_q[i] <= '0;
        end
      end else if (step_q >= 4'd3) begin
        if (step_q[0]) num_q[acc_c] <= TW'(prod_q);
        else num_q[acc_c] <= num_q[acc_c] - TW'(prod_q);
      end
    end
    if (state_q == StDiv) begin
      if (bit_q == '0) begin
        dvd_q <= num_mag;
        rem_q <= '0;
        qt_q  <= '0;
      end else begin
        dvd_q <= {dvd_q[NW-2:0], 1'b0};
        if (!rem_sub[TW]) begin rem_q <= rem_sub; qt_q <= {qt_q[NW-2:0], 1'b1}; end
        else begin rem_q <= rem_sh; qt_q <= {qt_q[NW-2:0], 1'b0}; end
      end
    end
    if (state_q == StFix) begin
      if (ovf) begin
        clip_q <= 1'b1;
        quo_q[comp_q] <= neg ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
      end else begin
        quo_q[comp_q] <= neg ? -qt_q[OW-1:0] : qt_q[OW-1:0];
      end
    end
  end

  assign res_o.valid            = (state_q == StOut);
  assign res_o.data.tangent_x   = quo_q[0];
  assign res_o.data.tangent_y   = quo_q[1];
  assign res_o.data.tangent_z   = quo_q[2];
  assign res_o.data.bitangent_x = quo_q[3];
  assign res_o.data.bitangent_y = quo_q[4];
  assign res_o.data.bitangent_z = quo_q[5];
  assign res_o.data.degenerate  = degen_q;
  assign res_o.data.clipped     = clip_q & ~degen_q;

endmodule

### hw/rtl/ttb_checker.sv
// Port-level checker for the triangle tangent basis core, with its bind.
// Depends on ttb_pkg and the core's ports.
module ttb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_degen,
  input logic out_clip,
  input logic [31:0] out_tx
);
  // no new vertex taken while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input ready while result pending");
  // result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  // degenerate results carry a zero tangent_x and no clip
  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_degen |-> out_tx == 32'd0 && !out_clip) else $error("bad degenerate");
endmodule

bind triangle_tangent_basis_core ttb_checker u_ttb_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (vtx_i.valid),
  .in_ready  (vtx_i.ready),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .out_degen (res_o.data.degenerate),
  .out_clip  (res_o.data.clipped),
  .out_tx    (res_o.data.tangent_x)
);

### bench/triangle_tangent_basis_checker.sv
// Checker for the triangle tangent basis core: tracks vertex requests, predicts
// each triangle's tangent basis and compares it with the result stream.
// Depends on ttb_pkg.
module triangle_tangent_basis_checker
  import ttb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vtx_valid_i,
  input  logic        vtx_ready_i,
  input  vertex_t     vtx_data_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  result_t     res_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned result_count_o,
  output int unsigned degen_count_o,
  output int unsigned clip_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint MaxQ = 64'sd2147483647;
  localparam longint MinQ = -64'sd2147483648;

  // Triangle assembly state
  logic [1:0] vertex_slot;
  vertex_t    held_vtx [2];
  result_t    basis_queue [$];

  // Truncated, saturated Q12.20 component of num / det
  function automatic logic [31:0] basis_component(longint num, longint det,
                                                  ref logic clip);
    longint q;
    q = (num <<< FracShift) / det;
    if (q > MaxQ) begin
      clip = 1'b1;
      q = MaxQ;
    end else if (q < MinQ) begin
      clip = 1'b1;
      q = MinQ;
    end
    return q[31:0];
  endfunction

  function automatic result_t tangent_basis(vertex_t v0, vertex_t v1, vertex_t v2);
    result_t r;
    longint e1 [3];
    longint e2 [3];
    longint du1, dv1, du2, dv2, det, tn, bn;
    logic clip;
    e1[0] = longint'(v1.pos_x) - longint'(v0.pos_x);
    e1[1] = longint'(v1.pos_y) - longint'(v0.pos_y);
    e1[2] = longint'(v1.pos_z) - longint'(v0.pos_z);
    e2[0] = longint'(v2.pos_x) - longint'(v0.pos_x);
    e2[1] = longint'(v2.pos_y) - longint'(v0.pos_y);
    e2[2] = longint'(v2.pos_z) - longint'(v0.pos_z);
    du1 = longint'(v1.tex_u) - longint'(v0.tex_u);
    dv1 = longint'(v1.tex_v) - longint'(v0.tex_v);
    du2 = longint'(v2.tex_u) - longint'(v0.tex_u);
    dv2 = longint'(v2.tex_v) - longint'(v0.tex_v);
    det = du1 * dv2 - du2 * dv1;
    r = '0;
    if (det == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    clip = 1'b0;
    tn = dv2 * e1[0] - dv1 * e2[0];
    bn = du1 * e2[0] - du2 * e1[0];
    r.tangent_x   = basis_component(tn, det, clip);
    r.bitangent_x = basis_component(bn, det, clip);
    tn = dv2 * e1[1] - dv1 * e2[1];
    bn = du1 * e2[1] - du2 * e1[1];
    r.tangent_y   = basis_component(tn, det, clip);
    r.bitangent_y = basis_component(bn, det, clip);
    tn = dv2 * e1[2] - dv1 * e2[2];
    bn = du1 * e2[2] - du2 * e1[2];
    r.tangent_z   = basis_component(tn, det, clip);
    r.bitangent_z = basis_component(bn, det, clip);
    r.clipped = clip;
    return r;
  endfunction

  assign pending_o = basis_queue.size();

  // Vertex side: hold two vertices, predict on the third
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_slot <= '0;
    end else if (vtx_valid_i && vtx_ready_i) begin
      if (vertex_slot < 2) begin
        held_vtx[vertex_slot] <= vtx_data_i;
        vertex_slot <= vertex_slot + 1'b1;
      end else begin
        basis_queue.insert(basis_queue.size(),
                           tangent_basis(held_vtx[0], held_vtx[1], vtx_data_i));
        vertex_slot <= '0;
      end
    end
  end

  // Result side: compare against the oldest prediction
  initial begin
    fail_count_o = 0;
    result_count_o = 0;
    degen_count_o = 0;
    clip_count_o = 0;
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_valid_i && res_ready_i) begin
      result_count_o <= result_count_o + 1;
      if (basis_queue.size() == 0) begin
        fail_count_o <= fail_count_o + 1;
        if (fail_count_o < 10)
          $display("ERROR: unexpected result %h", res_data_i);
      end else begin
        want = basis_queue.pop_front();
        if (want.degenerate) degen_count_o <= degen_count_o + 1;
        if (want.clipped) clip_count_o <= clip_count_o + 1;
        if (want.tangent_x !== res_data_i.tangent_x ||
            want.tangent_y !== res_data_i.tangent_y ||
            want.tangent_z !== res_data_i.tangent_z ||
            want.bitangent_x !== res_data_i.bitangent_x ||
            want.bitangent_y !== res_data_i.bitangent_y ||
            want.bitangent_z !== res_data_i.bitangent_z ||
            want.degenerate !== res_data_i.degenerate ||
            want.clipped !== res_data_i.clipped) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) begin
            $display("ERROR: basis mismatch at result %0d", result_count_o);
            $display("  exp t=%h %h %h b=%h %h %h dg=%b cl=%b", want.tangent_x,
                     want.tangent_y, want.tangent_z, want.bitangent_x,
                     want.bitangent_y, want.bitangent_z, want.degenerate, want.clipped);
            $display("  got t=%h %h %h b=%h %h %h dg=%b cl=%b", res_data_i.tangent_x,
                     res_data_i.tangent_y, res_data_i.tangent_z, res_data_i.bitangent_x,
                     res_data_i.bitangent_y, res_data_i.bitangent_z,
                     res_data_i.degenerate, res_data_i.clipped);
          end
        end
      end
    end
  end

endmodule

### bench/triangle_tangent_basis_core_test.sv
// Top of the triangle tangent basis bench: clock, reset, vertex stimulus,
// result back-pressure, watchdog and verdict.
// Depends on ttb_pkg, ttb_if, the core and triangle_tangent_basis_checker.
module triangle_tangent_basis_core_test;
  import ttb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomTriangles = 343;
  localparam int IdleLimit       = 6000;
  localparam int HoldOffCycles   = 1000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned fail_count, pending, result_count, degen_count, clip_count;
  int unsigned vertices_sent = 0;

  ttb_if #(.payload_t(vertex_t)) vtx ();
  ttb_if #(.payload_t(result_t)) res ();

  always #2 clk_i = ~clk_i;

  triangle_tangent_basis_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx),
    .res_o  (res)
  );

  triangle_tangent_basis_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vtx_valid_i    (vtx.valid),
    .vtx_ready_i    (vtx.ready),
    .vtx_data_i     (vtx.data),
    .res_valid_i    (res.valid),
    .res_ready_i    (res.ready),
    .res_data_i     (res.data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .degen_count_o  (degen_count),
    .clip_count_o   (clip_count)
  );

  // Sender burst/gap state
  int burst_left = 0;

  task automatic send_vertex(vertex_t v);
    vtx.valid <= 1'b1;
    vtx.data  <= v;
    do @(posedge clk_i); while (!vtx.ready);
    vertices_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        vtx.valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  endtask

  function automatic vertex_t mk_vtx(int px, int py, int pz, int tu, int tv);
    vertex_t v;
    v.pos_x = px[15:0];
    v.pos_y = py[15:0];
    v.pos_z = pz[15:0];
    v.tex_u = tu[15:0];
    v.tex_v = tv[15:0];
    return v;
  endfunction

  function automatic vertex_t rand_vtx();
    vertex_t v;
    v = vertex_t'(80'({$urandom(), $urandom(), $urandom()}));
    return v;
  endfunction

  // Offset a vertex by a small random amount per field
  function automatic vertex_t near_vtx(vertex_t b, int span);
    vertex_t v;
    v.pos_x = b.pos_x + 16'($urandom_range(0, 2 * span) - span);
    v.pos_y = b.pos_y + 16'($urandom_range(0, 2 * span) - span);
    v.pos_z = b.pos_z + 16'($urandom_range(0, 2 * span) - span);
    v.tex_u = b.tex_u + 16'($urandom_range(0, 2 * span) - span);
    v.tex_v = b.tex_v + 16'($urandom_range(0, 2 * span) - span);
    return v;
  endfunction

  // Reset and vertex stimulus
  initial begin
    vertex_t v0, v1, v2;
    int kind, span;
    vtx.valid = 1'b0;
    vtx.data  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unit UV square with extreme positions
    send_vertex(mk_vtx(32767, -32768, 0, 0, 0));
    send_vertex(mk_vtx(-32768, 32767, 256, 4096, 0));
    send_vertex(mk_vtx(0, 0, -256, 0, 4096));
    // Smallest determinant: saturation
    send_vertex(mk_vtx(-32768, -32768, -32768, 0, 0));
    send_vertex(mk_vtx(32767, 32767, 32767, 1, 0));
    send_vertex(mk_vtx(32767, -32768, 1, 0, 1));
    // Zero determinant: coincident texcoords
    send_vertex(mk_vtx(100, 200, 300, 1234, -1234));
    send_vertex(mk_vtx(-5, 7, 9, 1234, -1234));
    send_vertex(mk_vtx(11, -13, 17, 1234, -1234));
    // Extreme texcoords
    send_vertex(mk_vtx(0, 0, 0, -32768, -32768));
    send_vertex(mk_vtx(256, 0, 0, 32767, -32768));
    send_vertex(mk_vtx(0, 256, 0, -32768, 32767));
    // All zero: degenerate
    send_vertex(mk_vtx(0, 0, 0, 0, 0));
    send_vertex(mk_vtx(0, 0, 0, 0, 0));
    send_vertex(mk_vtx(0, 0, 0, 0, 0));
    // Negative determinant, collinear texcoords
    send_vertex(mk_vtx(10, 20, 30, 0, 0));
    send_vertex(mk_vtx(40, 50, 60, 0, 4096));
    send_vertex(mk_vtx(70, 80, 90, 4096, 0));
    send_vertex(mk_vtx(1, 2, 3, 100, 100));
    send_vertex(mk_vtx(4, 5, 6, 200, 200));
    send_vertex(mk_vtx(7, 8, 9, 300, 300));

    for (int t = 0; t < RandomTriangles; t++) begin
      // Drain once midway
      if (t == RandomTriangles / 2) begin
        vtx.valid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      kind = $urandom_range(0, 9);
      v0 = rand_vtx();
      if (kind < 3) begin
        v1 = rand_vtx();
        v2 = rand_vtx();
      end else if (kind < 9) begin
        span = (kind < 6) ? 64 : 4096;
        v1 = near_vtx(v0, span);
        v2 = near_vtx(v0, span);
        if (kind == 8) v2.tex_u = v1.tex_u;
        if (kind == 8) v2.tex_v = v1.tex_v;
        if (kind == 8 && $urandom_range(0, 1)) begin
          v1.tex_u = v0.tex_u;
          v1.tex_v = v0.tex_v;
        end
      end else begin
        v1 = near_vtx(v0, 2000);
        v2 = v1;
        v2.tex_u = v0.tex_u;
        v2.tex_v = v0.tex_v;
      end
      send_vertex(v0);
      send_vertex(v1);
      send_vertex(v2);
    end
    vtx.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (500) @(posedge clk_i);
    $display("Ran %0d vertices, %0d triangle results (%0d degenerate, %0d clipped).",
             vertices_sent, result_count, degen_count, clip_count);
    $display("Covered bursts, result stalls, one long hold-off and one full drain.");
    if (fail_count == 0 && pending == 0)
      $display("triangle_tangent_basis_core_test passed");
    else
      $display("triangle_tangent_basis_core_test failed");
    $finish;
  end

  // Result back-pressure: segments of differing stall density, one long hold-off
  initial begin
    int seg, mode, hold;
    bit held_once;
    seg = 0;
    mode = 0;
    hold = 0;
    held_once = 0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        res.ready <= 1'b0;
      end else if (!held_once && result_count >= 40) begin
        held_once = 1;
        hold = HoldOffCycles;
        res.ready <= 1'b0;
      end else begin
        if (seg == 0) begin
          seg = $urandom_range(1, 60);
          mode = $urandom_range(0, 2);
        end
        seg--;
        case (mode)
          0: res.ready <= 1'b1;
          1: res.ready <= 1'($urandom_range(0, 1));
          default: res.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles without any vertex or result handshake
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((vtx.valid && vtx.ready) || (res.valid && res.ready)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("triangle_tangent_basis_core_test failed");
        $finish;
      end
    end
  end

endmodule

### filelist.f
hw/rtl/ttb_pkg.sv
hw/rtl/ttb_if.sv
hw/rtl/triangle_tangent_basis_core.sv
hw/rtl/ttb_checker.sv
bench/triangle_tangent_basis_checker.sv
bench/triangle_tangent_basis_core_test.sv
